### design/dsd_block_deinterleaver_unit_macros.svh
// ----------------------------------------------------------------------------
// DSD block deinterleaver assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DSD_BLOCK_DEINTERLEAVER_UNIT_MACROS_SVH
`define DSD_BLOCK_DEINTERLEAVER_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define DSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define DSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Types, codes and helpers shared by the DSD block deinterleaver modules.
// ----------------------------------------------------------------------------
package dsd_pkg;

  localparam int unsigned MAX_CHANNELS = 6;
  localparam int unsigned Q_DEPTH      = 4;
  localparam int unsigned RA_W         = 16;
  localparam logic [12:0] OFFSET_MAX   = 13'd8191;
  localparam logic [14:0] FILL_MAX     = 15'd32767;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BYTES   = 2'd1;
  localparam logic [1:0] CFG_LSB_FIRST     = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       block_start;
  } in_item_t;

  typedef struct packed {
    logic       sample_valid;
    logic [7:0] chan0_byte;
    logic [7:0] chan1_byte;
    logic [7:0] chan2_byte;
    logic [7:0] chan3_byte;
    logic [7:0] chan4_byte;
    logic [7:0] chan5_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [14:0] pos;
    logic [7:0]  data;
    logic [2:0]  ch;
    logic [12:0] bb;
    logic        lsb;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_LAST
  } back_state_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7 - k] = b[k];
    end
    return r;
  endfunction

endpackage

### design/dsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_front
// Configuration registers, fill count and read offset; classifies each
// accepted item into a store write, a group read or an exhausted read.
// ----------------------------------------------------------------------------
module dsd_front
  import dsd_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  output logic        push,
  output cmd_t        cmd
);

  localparam int unsigned STORE_DEPTH = MAX_CHANNELS * MAX_BLOCK_BYTES;

  logic [2:0]  ch_cfg_r;
  logic [12:0] bb_cfg_r;
  logic        lsb_r;
  logic [14:0] fill_r, fill_nxt;
  logic [12:0] off_r, off_nxt;

  logic [2:0]  ch_eff;
  logic [12:0] bb_eff;
  logic [15:0] cap;
  logic [15:0] used;
  logic [14:0] fill_b;
  logic [12:0] off_b;
  logic        can_store;
  logic        exhausted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cfg_r <= 3'd2;
      bb_cfg_r <= 13'd4096;
      lsb_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: ch_cfg_r <= cfg_wdata[2:0];
        CFG_BLOCK_BYTES:   bb_cfg_r <= cfg_wdata;
        CFG_LSB_FIRST:     lsb_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp configuration into the supported range.
  always_comb begin
    ch_eff = ch_cfg_r;
    if (ch_cfg_r == 3'd0) begin
      ch_eff = 3'd1;
    end else if (32'(ch_cfg_r) > MAX_CHANNELS) begin
      ch_eff = 3'(MAX_CHANNELS);
    end
    bb_eff = bb_cfg_r;
    if (bb_cfg_r == 13'd0) begin
      bb_eff = 13'd1;
    end else if (32'(bb_cfg_r) > MAX_BLOCK_BYTES) begin
      bb_eff = 13'(MAX_BLOCK_BYTES);
    end
  end

  assign cap  = 16'(16'(ch_eff) * 16'(bb_eff));
  assign used = 16'(16'(off_r) * 16'(ch_eff));

  assign fill_b    = in_data.block_start ? 15'd0 : fill_r;
  assign off_b     = in_data.block_start ? 13'd0 : off_r;
  assign can_store = ({1'b0, fill_b} < cap) && (32'(fill_b) < STORE_DEPTH) &&
                     (fill_b != FILL_MAX);
  assign exhausted = used >= {1'b0, fill_r};

  always_comb begin
    fill_nxt = fill_r;
    off_nxt  = off_r;
    push     = 1'b0;
    cmd.kind = CMD_LOAD;
    cmd.pos  = fill_b;
    cmd.data = in_data.data_byte;
    cmd.ch   = ch_eff;
    cmd.bb   = bb_eff;
    cmd.lsb  = lsb_r;
    if (accept) begin
      if (in_data.mode == MODE_LOAD) begin
        off_nxt  = off_b;
        fill_nxt = can_store ? fill_b + 15'd1 : fill_b;
        push     = can_store;
      end else begin
        push     = 1'b1;
        cmd.pos  = {2'b00, off_r};
        cmd.kind = exhausted ? CMD_EMPTY : CMD_READ;
        if (!exhausted && off_r != OFFSET_MAX) begin
          off_nxt = off_r + 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      off_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      off_r  <= off_nxt;
    end
  end

endmodule

### design/dsd_cmdq.sv
`timescale 1ns / 1ps
`include "dsd_block_deinterleaver_unit_macros.svh"
// ----------------------------------------------------------------------------
// dsd_cmdq
// Short command queue between the classifier and the store sequencer.
// ----------------------------------------------------------------------------
module dsd_cmdq
  import dsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  localparam int unsigned PW = $clog2(Q_DEPTH);
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  cmd_t          slot_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = count_r == CW'(Q_DEPTH);
  assign stat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: ;
      endcase
    end
  end

  `DSD_ASSERT_SAME(a_no_overflow, stat.full && !pop, !push, "command queue overflow")
  `DSD_ASSERT_SAME(a_no_underflow, stat.empty, !pop, "command queue underflow")

endmodule

### design/dsd_back.sv
`timescale 1ns / 1ps
`include "dsd_block_deinterleaver_unit_macros.svh"
// ----------------------------------------------------------------------------
// dsd_back
// Block store and its sequencer: clears the store after reset, carries out
// queued writes, reads one byte per channel and assembles the result.
// ----------------------------------------------------------------------------
module dsd_back
  import dsd_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  q_stat_t    qstat,
  output logic       pop,
  output back_stat_t stat,
  output logic       out_strobe,
  output out_item_t  out_data
);

  localparam int unsigned STORE_DEPTH = MAX_CHANNELS * MAX_BLOCK_BYTES;
  localparam int unsigned AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned AXW = (AW > RA_W) ? AW : RA_W;

  logic [7:0] mem [STORE_DEPTH];

  back_state_t   st_r, st_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [2:0]    chan_r, chan_nxt;
  logic [AXW-1:0] raddr_r, raddr_nxt;
  logic          pend_r, pend_nxt;
  logic [2:0]    pend_chan_r, pend_chan_nxt;
  logic          pend_ok_r, pend_ok_nxt;
  logic [7:0]    mem_q_r;
  logic [7:0]    group_r [MAX_CHANNELS];
  logic [7:0]    group_nxt [MAX_CHANNELS];
  logic          out_strobe_r, out_strobe_nxt;
  out_item_t     out_r, out_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AXW-1:0] pos_ext;
  logic          rd_ok;
  logic [7:0]    cap_byte;

  assign pos_ext       = AXW'(head.pos);
  assign rd_ok         = 32'(raddr_r) < STORE_DEPTH;
  assign stat.clearing = st_r == BK_CLEAR;
  assign out_strobe    = out_strobe_r;
  assign out_data      = out_r;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_CLEAR: begin
        if (clr_addr_r == AW'(STORE_DEPTH - 1)) st_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!qstat.empty && head.kind == CMD_READ) st_nxt = BK_READ;
      end
      BK_READ: begin
        if (chan_r == cmd_r.ch - 3'd1) st_nxt = BK_LAST;
      end
      BK_LAST: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_wdata      = 8'd0;
    mem_re         = 1'b0;
    pop            = 1'b0;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    chan_nxt       = chan_r;
    raddr_nxt      = raddr_r;
    pend_nxt       = 1'b0;
    pend_chan_nxt  = pend_chan_r;
    pend_ok_nxt    = pend_ok_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    group_nxt      = group_r;

    // Drop a byte that came from beyond the store.
    cap_byte = 8'd0;
    if (pend_ok_r) begin
      cap_byte = cmd_r.lsb ? bit_rev8(mem_q_r) : mem_q_r;
    end
    if (pend_r) begin
      group_nxt[pend_chan_r] = cap_byte;
    end

    case (st_r)
      BK_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = pos_ext[AW-1:0];
              mem_wdata = head.data;
            end
            CMD_READ: begin
              cmd_nxt   = head;
              chan_nxt  = 3'd0;
              raddr_nxt = pos_ext;
              for (int c = 0; c < MAX_CHANNELS; c++) begin
                group_nxt[c] = 8'd0;
              end
            end
            CMD_EMPTY: begin
              out_strobe_nxt = 1'b1;
              out_nxt        = '0;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        mem_re        = rd_ok;
        pend_nxt      = 1'b1;
        pend_chan_nxt = chan_r;
        pend_ok_nxt   = rd_ok;
        chan_nxt      = chan_r + 3'd1;
        raddr_nxt     = raddr_r + AXW'(cmd_r.bb);
      end
      BK_LAST: begin
        out_strobe_nxt       = 1'b1;
        out_nxt.sample_valid = 1'b1;
        out_nxt.chan0_byte   = group_nxt[0];
        out_nxt.chan1_byte   = group_nxt[1];
        out_nxt.chan2_byte   = group_nxt[2];
        out_nxt.chan3_byte   = group_nxt[3];
        out_nxt.chan4_byte   = group_nxt[4];
        out_nxt.chan5_byte   = group_nxt[5];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= mem[raddr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= BK_CLEAR;
      clr_addr_r   <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      clr_addr_r   <= clr_addr_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    chan_r      <= chan_nxt;
    raddr_r     <= raddr_nxt;
    pend_chan_r <= pend_chan_nxt;
    pend_ok_r   <= pend_ok_nxt;
    out_r       <= out_nxt;
    group_r     <= group_nxt;
  end

  `DSD_ASSERT_NEXT(a_last_emits, st_r == BK_LAST, out_strobe_r && out_r.sample_valid,
                   "group read finished without a valid result")
  `DSD_ASSERT_SAME(a_pend_chan, pend_r, pend_chan_r < cmd_r.ch,
                   "byte captured for a channel beyond the group")
  `DSD_ASSERT_SAME(a_read_cmd, st_r == BK_READ, cmd_r.kind == CMD_READ,
                   "group read running without a read command")
  `DSD_ASSERT_SAME(a_no_pop_clear, st_r == BK_CLEAR, !pop && !out_strobe_r,
                   "command taken while the store is being cleared")

endmodule

### design/dsd_block_deinterleaver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_block_deinterleaver_unit
// Turns block-planar DSD bytes into channel-interleaved sample groups.
// ----------------------------------------------------------------------------
// After reset the block clears its block store, one byte a cycle, and holds
// busy high until the whole store is clear; config writes are taken during
// that time. An item transfers when start is high and busy is low. The store
// sequencer writes a load item as it takes the command; for a read item it
// takes the command, reads one byte per channel on the single store read
// port and then assembles the group. A read of an exhausted block gives an
// all-zero result. A four-entry command queue sits between the classifier
// and the sequencer, so the block keeps taking items until that queue fills;
// busy then stays high until the sequencer frees a slot. Every read gives
// exactly one result on out_data, shown for one cycle with out_strobe high;
// the receiver cannot stall, so take it in that cycle. Loads give no result.
// Change configuration only once all results are out and the queue has
// drained.
// ----------------------------------------------------------------------------
module dsd_block_deinterleaver_unit
  import dsd_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_strobe,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  logic       accept;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       head;
  q_stat_t    qstat;
  back_stat_t bstat;

  // Hold items off while the store is cleared or the queue is full.
  assign busy   = bstat.clearing || qstat.full;
  assign accept = start && !busy;

  // Classify items and keep the fill count and read offset.
  dsd_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Decouple the classifier from the store sequencer.
  dsd_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  // Write the store and read out interleaved groups.
  dsd_back #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .stat       (bstat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dsd_block_deinterleaver_unit. A behavioral copy of
// the block store, fill count and read offset predicts every sample group;
// each strobed group is compared field by field with the oldest prediction.
// Directed tests cover defaults, register extremes and mid-block changes, then
// random block sequences run under several sender idle profiles.
// ----------------------------------------------------------------------------
module tb_top;
  import dsd_pkg::*;

  localparam int unsigned BLOCK_LIMIT   = 4096;
  localparam int unsigned STORE_BYTES   = MAX_CHANNELS * BLOCK_LIMIT;
  localparam int unsigned SETTLE_CYCLES = 64;       // lets a full queue of 4 reads drain
  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int unsigned RANDOM_ITEMS  = 815;
  localparam int unsigned ERR_PRINT_MAX = 30;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_strobe;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;

  // Predicted block state and register image.
  logic [7:0]  store_img [STORE_BYTES];
  logic [14:0] fill_cnt;
  logic [12:0] rd_pos;
  logic [2:0]  reg_lanes;
  logic [12:0] reg_block;
  logic        reg_lsb_first;

  out_item_t   expected_groups [$];
  int unsigned fail_count  = 0;
  int unsigned items_taken = 0;
  int unsigned idle_pct    = 0;
  int unsigned cycle_count = 0;

  dsd_block_deinterleaver_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Safety net: a lost group or a stuck busy ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] mirror_byte(input logic [7:0] b);
    logic [7:0] m;
    foreach (m[i]) m[i] = b[7 - i];
    return m;
  endfunction

  // Clamp the channel register: 0 acts as 1, anything above the max as the max.
  function automatic int unsigned lanes_in_use();
    if (reg_lanes == 3'd0) return 1;
    if (32'(reg_lanes) > MAX_CHANNELS) return MAX_CHANNELS;
    return 32'(reg_lanes);
  endfunction

  function automatic int unsigned block_len();
    if (reg_block == 13'd0) return 1;
    if (32'(reg_block) > BLOCK_LIMIT) return BLOCK_LIMIT;
    return 32'(reg_block);
  endfunction

  task automatic clear_prediction();
    foreach (store_img[i]) store_img[i] = 8'h00;
    fill_cnt      = '0;
    rd_pos        = '0;
    reg_lanes     = 3'd2;
    reg_block     = 13'd4096;
    reg_lsb_first = 1'b1;
  endtask

  // Advance the predicted state by one accepted item; a read queues one group.
  // stored is low only for a load dropped at capacity.
  task automatic predict_group(input in_item_t it, output bit stored);
    int unsigned nch, nbb, pos, addr;
    logic [48:0] grp;
    logic [7:0]  b;
    nch    = lanes_in_use();
    nbb    = block_len();
    stored = 1'b1;
    if (it.mode == MODE_LOAD) begin
      // A block start clears the count and offset before the byte is stored.
      if (it.block_start) begin
        fill_cnt = '0;
        rd_pos   = '0;
      end
      if (32'(fill_cnt) < nch * nbb && 32'(fill_cnt) < STORE_BYTES &&
          fill_cnt < FILL_MAX) begin
        store_img[fill_cnt] = it.data_byte;
        fill_cnt            = fill_cnt + 15'd1;
      end else begin
        stored = 1'b0;
      end
    end else begin
      grp = '0;
      pos = 32'(rd_pos);
      // Exhausted block: all zeros, offset held.
      if (pos * nch < 32'(fill_cnt)) begin
        grp[48] = 1'b1;
        for (int unsigned c = 0; c < nch; c++) begin
          addr = c * nbb + pos;
          b    = (addr < STORE_BYTES) ? store_img[15'(addr)] : 8'h00;
          if (reg_lsb_first) b = mirror_byte(b);
          grp[(5 - c) * 8 +: 8] = b;
        end
        if (rd_pos != OFFSET_MAX) rd_pos = rd_pos + 13'd1;
      end
      expected_groups.push_back(out_item_t'(grp));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every strobe is one transfer the receiver must take.
  // --------------------------------------------------------------------------
  task automatic check_group(input out_item_t got);
    string       names [7];
    logic [48:0] ev, av;
    logic [7:0]  e, a;
    out_item_t   want;
    names = '{"sample_valid", "chan0_byte", "chan1_byte", "chan2_byte",
              "chan3_byte", "chan4_byte", "chan5_byte"};
    if (expected_groups.size() == 0) begin
      if (fail_count < ERR_PRINT_MAX)
        $display("%0t MISMATCH unexpected group %h", $time, got);
      fail_count++;
    end else begin
      want = expected_groups.pop_front();
      ev   = want;
      av   = got;
      for (int k = 0; k < 7; k++) begin
        if (k == 0) begin
          e = {7'd0, ev[48]};
          a = {7'd0, av[48]};
        end else begin
          e = ev[(6 - k) * 8 +: 8];
          a = av[(6 - k) * 8 +: 8];
        end
        if (e !== a) begin
          if (fail_count < ERR_PRINT_MAX)
            $display("%0t MISMATCH %s: expected %h, actual %h", $time, names[k], e, a);
          fail_count++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) check_group(out_data);
  end

  // --------------------------------------------------------------------------
  // Bus tasks
  // --------------------------------------------------------------------------
  // Drive one command, hold it until the block takes it, then predict.
  // Idle gaps are inserted ahead of the item at the current idle rate.
  task automatic send_item(input logic mode, input logic [7:0] data, input logic first);
    in_item_t it;
    bit       stored;
    it.mode        = mode;
    it.data_byte   = data;
    it.block_start = first;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_group(it, stored);
    if (stored) items_taken++;
  endtask

  // Register write: one cycle of write enable, applied to the image at the edge.
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CHANNEL_COUNT: reg_lanes     = val[2:0];
      CFG_BLOCK_BYTES:   reg_block     = val;
      CFG_LSB_FIRST:     reg_lsb_first = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop start and hold until every predicted group has arrived.
  task automatic wait_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
  endtask

  // Full quiesce before a register write: loads still in the command queue
  // produce no group, so give the sequencer time to empty it.
  task automatic settle_idle();
    wait_results();
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset defaults: two channels, 4096-byte blocks, LSB-first output.
  // The second channel of the group reads a never-loaded byte, zero after reset.
  task automatic test_reset_state();
    send_item(MODE_READ, 8'h00, 1'b0);   // nothing loaded yet: exhausted
    send_item(MODE_LOAD, 8'h01, 1'b1);
    send_item(MODE_LOAD, 8'h80, 1'b0);
    send_item(MODE_READ, 8'h5A, 1'b0);
    send_item(MODE_READ, 8'hFF, 1'b1);   // offset 1 of a 2-byte fill: exhausted
  endtask

  // Register extremes, out-of-range clamps, capacity overflow, ignored fields.
  task automatic test_field_extremes();
    logic [7:0] pattern [7];
    pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h3C};
    settle_idle();
    // Zero channels and zero block size both act as one.
    write_reg(CFG_CHANNEL_COUNT, 13'd0);
    write_reg(CFG_BLOCK_BYTES, 13'd0);
    write_reg(CFG_LSB_FIRST, 13'd0);
    send_item(MODE_LOAD, 8'hFF, 1'b1);
    send_item(MODE_LOAD, 8'h00, 1'b0);   // beyond capacity: dropped
    send_item(MODE_READ, 8'hFF, 1'b1);
    send_item(MODE_READ, 8'h00, 1'b0);
    settle_idle();
    // Seven channels clamp to six; one byte per channel plus one dropped load.
    write_reg(CFG_CHANNEL_COUNT, 13'd7);
    write_reg(CFG_BLOCK_BYTES, 13'd1);
    write_reg(CFG_LSB_FIRST, 13'd1);
    foreach (pattern[i]) send_item(MODE_LOAD, pattern[i], i == 0);
    send_item(MODE_READ, 8'h00, 1'b0);
    send_item(MODE_READ, 8'h00, 1'b0);
    settle_idle();
    // Largest register value clamps to the maximum block size.
    write_reg(CFG_CHANNEL_COUNT, 13'd6);
    write_reg(CFG_BLOCK_BYTES, 13'h1FFF);
    write_reg(CFG_LSB_FIRST, 13'd0);
    send_item(MODE_LOAD, 8'h12, 1'b1);
    send_item(MODE_LOAD, 8'h34, 1'b0);
    send_item(MODE_READ, 8'h00, 1'b0);
    send_item(MODE_READ, 8'h00, 1'b0);
  endtask

  // Geometry changes in the middle of a block take effect at once, and a
  // short new block exposes bytes left over from the previous one.
  task automatic test_config_midblock();
    settle_idle();
    write_reg(CFG_CHANNEL_COUNT, 13'd2);
    write_reg(CFG_BLOCK_BYTES, 13'd3);
    for (int i = 0; i < 6; i++) send_item(MODE_LOAD, 8'(8'h10 + i), i == 0);
    send_item(MODE_READ, 8'h00, 1'b0);
    settle_idle();
    write_reg(CFG_CHANNEL_COUNT, 13'd3);
    write_reg(CFG_BLOCK_BYTES, 13'd2);
    write_reg(CFG_LSB_FIRST, 13'd1);
    send_item(MODE_READ, 8'h00, 1'b0);
    send_item(MODE_READ, 8'h00, 1'b0);
    settle_idle();
    write_reg(CFG_CHANNEL_COUNT, 13'd2);
    write_reg(CFG_BLOCK_BYTES, 13'd3);
    send_item(MODE_LOAD, 8'hC3, 1'b1);   // one-byte block
    send_item(MODE_READ, 8'h00, 1'b0);   // channel 1 shows the old byte
    send_item(MODE_READ, 8'h00, 1'b0);
  endtask

  // Random blocks: mostly well-formed fill-then-drain sequences with random
  // geometry and data, salted with stray reads, restarts and overfills.
  task automatic test_random_blocks();
    int unsigned base, blk, r, cap, nload, nread, nch;
    int unsigned idle_profile [4];
    idle_profile = '{0, 66, 36, 0};
    base = items_taken;
    blk  = 0;
    while (items_taken - base < RANDOM_ITEMS) begin
      settle_idle();
      idle_pct = idle_profile[2'((blk / 5) % 4)];
      write_reg(CFG_CHANNEL_COUNT, 13'($urandom_range(7)));
      r = $urandom_range(99);
      if (r < 75)      write_reg(CFG_BLOCK_BYTES, 13'($urandom_range(6, 1)));
      else if (r < 85) write_reg(CFG_BLOCK_BYTES, 13'($urandom_range(32, 7)));
      else if (r < 90) write_reg(CFG_BLOCK_BYTES, 13'd0);
      else if (r < 95) write_reg(CFG_BLOCK_BYTES, 13'($urandom_range(8191, 4096)));
      else             write_reg(CFG_BLOCK_BYTES, 13'd4096);
      write_reg(CFG_LSB_FIRST, 13'($urandom_range(1)));
      nch = lanes_in_use();
      cap = nch * block_len();
      // Overfill small blocks now and then to hit the capacity drop.
      if (cap <= 40 && $urandom_range(99) < 20) nload = cap + $urandom_range(3, 1);
      else nload = $urandom_range((cap < 40) ? cap : 40, 1);
      for (int unsigned i = 0; i < nload; i++) begin
        if ($urandom_range(99) < 4) send_item(MODE_READ, 8'($urandom), 1'($urandom));
        send_item(MODE_LOAD, 8'($urandom), (i == 0) || ($urandom_range(99) < 2));
      end
      // Drain the block and run a little past its end.
      nread = (32'(fill_cnt) + nch - 1) / nch + $urandom_range(2);
      for (int unsigned i = 0; i < nread; i++) begin
        send_item(MODE_READ, 8'($urandom), 1'($urandom));
      end
      // Occasionally pause the sender until the pipe is empty.
      if ($urandom_range(9) == 0) wait_results();
      blk++;
    end
    idle_pct = 0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    clear_prediction();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The store clear after reset keeps busy high; send_item waits it out.
    test_reset_state();
    test_field_extremes();
    test_config_midblock();
    test_random_blocks();

    settle_idle();
    if (fail_count == 0 && expected_groups.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
